>>> rtl/core/gsat_pkg.sv
package gsat_pkg;

	localparam int TAG_W  = 16;
	localparam int NODE_W = 3;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 7;
	localparam int CFG_W  = 32;
	localparam int NIB_W  = 4;

	typedef enum logic [1:0] {
		FN_PAIR    = 2'd0,
		FN_RELEASE = 2'd1,
		FN_QUERY   = 2'd2,
		FN_READ    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_GRANT    = 3'd0,
		ST_REJECT   = 3'd1,
		ST_RELEASED = 3'd2,
		ST_ANSWER   = 3'd3,
		ST_BAD      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic pair_chk;
		logic scan_clr;
		logic step;
		logic rd_issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  last;
		logic  scan_end;
		logic  failed;
		logic  cap_zero;
		logic  out_free;
	} sts_t;

endpackage

>>> rtl/core/gpu_slot_allocation_table_top.sv
// a non-final pair returns no result; a final pair scans the whole table, or stops early if rejected
// release scans the whole table then drains; free count scans the node's capacity (absent node: no scan)
// throughput: one transaction at a time, set by the one-slot-per-cycle table scan
// the next transaction is taken while the previous result waits in the output register
// reset clears configuration, busy and pending bits, failure flag and occupancy count
// owner memory is not cleared and its read data is used only for busy slots
module gpu_slot_allocation_table_top
	import gsat_pkg::*;
#(
	parameter int NODES          = 8,
	parameter int SLOTS_PER_NODE = 8,
	parameter int TAG_BITS       = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [TAG_W-1:0]  job_tag,
	input  logic [NODE_W-1:0] node_sel,
	input  logic [SLOT_W-1:0] slot_sel,
	input  logic              last_pair,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  count,
	output logic [CNT_W-1:0]  used_total,
	output logic              slot_busy_out,
	output logic [TAG_W-1:0]  owner_tag
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	gsat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	gsat_dp #(
		.NODES          (NODES),
		.SLOTS_PER_NODE (SLOTS_PER_NODE),
		.TAG_BITS       (TAG_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.func          (func),
		.job_tag       (job_tag),
		.node_sel      (node_sel),
		.slot_sel      (slot_sel),
		.last_pair     (last_pair),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.count         (count),
		.used_total    (used_total),
		.slot_busy_out (slot_busy_out),
		.owner_tag     (owner_tag)
	);

endmodule

>>> rtl/core/gsat_ctrl.sv
module gsat_ctrl
	import gsat_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (sts.func)
					FN_PAIR:    state_d = sts.last ? S_SCAN : S_IDLE;
					FN_RELEASE: state_d = S_SCAN;
					FN_QUERY:   state_d = sts.cap_zero ? S_FINISH : S_SCAN;
					FN_READ:    state_d = S_FINISH;
				endcase
			end
			S_SCAN: begin
				if (sts.func == FN_PAIR && sts.failed) begin
					state_d = S_FINISH;
				end else if (sts.scan_end) begin
					state_d = (sts.func == FN_RELEASE) ? S_DRAIN : S_FINISH;
				end
			end
			S_DRAIN: state_d = S_FINISH;
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				cmd.pair_chk = (sts.func == FN_PAIR);
				cmd.scan_clr = (sts.func == FN_PAIR && sts.last) || (sts.func == FN_RELEASE)
					|| (sts.func == FN_QUERY && !sts.cap_zero);
				cmd.rd_issue = (sts.func == FN_READ);
			end
			S_SCAN: begin
				cmd.step = !(sts.func == FN_PAIR && sts.failed);
			end
			S_DRAIN: begin
				cmd = '0;
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded while output register occupied");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("input ready outside idle state");

endmodule

>>> rtl/core/gsat_dp.sv
module gsat_dp
	import gsat_pkg::*;
#(
	parameter int NODES          = 8,
	parameter int SLOTS_PER_NODE = 8,
	parameter int TAG_BITS       = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [1:0]        func,
	input  logic [TAG_W-1:0]  job_tag,
	input  logic [NODE_W-1:0] node_sel,
	input  logic [SLOT_W-1:0] slot_sel,
	input  logic              last_pair,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  count,
	output logic [CNT_W-1:0]  used_total,
	output logic              slot_busy_out,
	output logic [TAG_W-1:0]  owner_tag
);

	localparam int TOTAL = NODES * SLOTS_PER_NODE;
	localparam int IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CW    = $clog2(TOTAL + 1);
	localparam int OW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	logic [CFG_W-1:0]  cfg_q;
	func_t             func_q;
	logic [TAG_W-1:0]  tag_q;
	logic [NODE_W-1:0] node_q;
	logic [SLOT_W-1:0] slot_q;
	logic              last_q;

	logic [TOTAL-1:0]  busy_q;
	logic [TOTAL-1:0]  pending_q;
	logic              fail_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     acc_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     idx_s1;
	logic              rel_vld_s1;

	logic [OW-1:0]     owner_mem [TOTAL];
	logic [OW-1:0]     rdata_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  used_out_q;
	logic              busy_out_q;
	logic [TAG_W-1:0]  owner_out_q;

	logic [NIB_W-1:0]  nib;
	logic              node_ok;
	logic [NIB_W-1:0]  cap;
	logic              cap_zero;
	logic              slot_ok;
	logic [IW-1:0]     base;
	logic [IW-1:0]     idx_item;
	logic [IW-1:0]     end_idx;
	logic [IW-1:0]     rd_addr;
	logic              commit_wr;
	logic              rel_step;
	logic              rel_hit;
	logic              qry_hit;
	logic [CW:0]       used_sum;
	logic [CW-1:0]     used_d;
	status_t           status_d;
	logic [CW-1:0]     count_d;
	logic              busy_out_d;
	logic [OW-1:0]     owner_d;
	logic              out_free;

	assign nib      = cfg_q[{node_q, 2'b00} +: NIB_W];
	assign node_ok  = (32'(node_q) < NODES);
	assign cap      = !node_ok ? '0
		: (32'(nib) > SLOTS_PER_NODE) ? NIB_W'(SLOTS_PER_NODE) : nib;
	assign cap_zero = (cap == '0);
	assign slot_ok  = !cap_zero && (slot_q < cap);
	assign base     = IW'(32'(node_q) * SLOTS_PER_NODE);
	assign idx_item = base + IW'(slot_q);
	assign end_idx  = (func_q == FN_QUERY) ? (base + IW'(cap) - IW'(1)) : IW'(TOTAL - 1);
	assign rd_addr  = cmd.rd_issue ? idx_item : idx_q;

	assign commit_wr = cmd.step && (func_q == FN_PAIR) && pending_q[idx_q] && !busy_q[idx_q];
	assign rel_step  = cmd.step && (func_q == FN_RELEASE);
	assign rel_hit   = rel_vld_s1 && busy_q[idx_s1] && (rdata_q == tag_q[OW-1:0]);
	assign qry_hit   = cmd.step && (func_q == FN_QUERY) && !busy_q[idx_q];
	assign out_free  = !out_valid_q || out_ready;

	assign sts.func     = func_q;
	assign sts.last     = last_q;
	assign sts.scan_end = (idx_q == end_idx);
	assign sts.failed   = fail_q;
	assign sts.cap_zero = cap_zero;
	assign sts.out_free = out_free;

	// occupancy after the item
	always_comb begin
		used_sum = (CW + 1)'(used_q) + (CW + 1)'(acc_q);
		used_d   = used_q;
		unique case (func_q)
			FN_PAIR: begin
				if (!fail_q) begin
					used_d = (used_sum > (CW + 1)'(TOTAL)) ? CW'(TOTAL) : CW'(used_sum);
				end
			end
			FN_RELEASE: used_d = (used_q > acc_q) ? (used_q - acc_q) : '0;
			FN_QUERY:   used_d = used_q;
			FN_READ:    used_d = used_q;
		endcase
	end

	always_comb begin
		status_d   = ST_BAD;
		count_d    = '0;
		busy_out_d = 1'b0;
		owner_d    = '0;
		unique case (func_q)
			FN_PAIR: begin
				status_d = fail_q ? ST_REJECT : ST_GRANT;
				count_d  = fail_q ? '0 : acc_q;
			end
			FN_RELEASE: begin
				status_d = ST_RELEASED;
				count_d  = acc_q;
			end
			FN_QUERY: begin
				status_d = cap_zero ? ST_BAD : ST_ANSWER;
				count_d  = cap_zero ? '0 : acc_q;
			end
			FN_READ: begin
				if (slot_ok) begin
					status_d   = ST_ANSWER;
					busy_out_d = busy_q[idx_item];
					owner_d    = busy_q[idx_item] ? rdata_q : '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit_wr) owner_mem[idx_q] <= tag_q[OW-1:0];
		if (cmd.rd_issue || rel_step) rdata_q <= owner_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			tag_q  <= job_tag;
			node_q <= node_sel;
			slot_q <= slot_sel;
			last_q <= last_pair;
		end
		if (cmd.scan_clr) begin
			idx_q <= (func_q == FN_QUERY) ? base : '0;
			acc_q <= '0;
		end else begin
			if (cmd.step) idx_q <= idx_q + IW'(1);
			if (commit_wr || rel_hit || qry_hit) acc_q <= acc_q + CW'(1);
		end
		idx_s1 <= idx_q;
		if (cmd.finish) begin
			status_q    <= status_d;
			count_q     <= CNT_W'(count_d);
			used_out_q  <= CNT_W'(used_d);
			busy_out_q  <= busy_out_d;
			owner_out_q <= TAG_W'(owner_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			busy_q      <= '0;
			pending_q   <= '0;
			fail_q      <= 1'b0;
			used_q      <= '0;
			rel_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) cfg_q <= cfg_data;
			rel_vld_s1 <= rel_step;
			if (cmd.pair_chk) begin
				if (!slot_ok || busy_q[idx_item]) begin
					fail_q <= 1'b1;
				end else begin
					pending_q[idx_item] <= 1'b1;
				end
			end
			if (commit_wr) busy_q[idx_q] <= 1'b1;
			if (rel_hit) busy_q[idx_s1] <= 1'b0;
			if (cmd.finish) begin
				used_q <= used_d;
				if (func_q == FN_PAIR) begin
					pending_q <= '0;
					fail_q    <= 1'b0;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign count         = count_q;
	assign used_total    = used_out_q;
	assign slot_busy_out = busy_out_q;
	assign owner_tag     = owner_out_q;

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TOTAL))
		else $error("occupancy count above table size");

	a_used_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (32'(used_q) == $countones(busy_q)))
		else $error("occupancy count out of step with busy bits");

	a_pending_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> ((pending_q & busy_q) == '0))
		else $error("pending mark on busy slot between transactions");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import gsat_pkg::*;

	localparam int SPN   = 8;
	localparam int TOTAL = 8 * SPN;
	localparam int DRAIN = 80;
	localparam int LIMIT = 1000000;

	typedef struct packed {
		status_t          st;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] used;
		logic             busy;
		logic [TAG_W-1:0] owner;
	} alloc_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CFG_W-1:0]  cdata;
		func_t             f;
		logic [TAG_W-1:0]  tag;
		logic [NODE_W-1:0] node;
		logic [SLOT_W-1:0] slot;
		logic              last;
		logic              typed;
		alloc_result_t     res;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [TAG_W-1:0]  job_tag;
	logic [NODE_W-1:0] node_sel;
	logic [SLOT_W-1:0] slot_sel;
	logic              last_pair;
	logic              out_valid;
	logic              out_ready;
	logic [2:0]        status;
	logic [CNT_W-1:0]  count;
	logic [CNT_W-1:0]  used_total;
	logic              slot_busy_out;
	logic [TAG_W-1:0]  owner_tag;

	// mirror of the allocation table
	logic [CFG_W-1:0] cap_word;
	bit               slot_taken [TOTAL];
	logic [TAG_W-1:0] slot_tag [TOTAL];
	bit               slot_pend [TOTAL];
	bit               req_bad;
	int               occupied;

	alloc_result_t    results_due [$];
	plan_row_t        plan [$];
	logic [TAG_W-1:0] tag_pool [8];

	int mismatches = 0;
	int cycles = 0;
	int items_sent = 0;
	int send_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	bit offer_up = 0;

	gpu_slot_allocation_table_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.job_tag       (job_tag),
		.node_sel      (node_sel),
		.slot_sel      (slot_sel),
		.last_pair     (last_pair),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.count         (count),
		.used_total    (used_total),
		.slot_busy_out (slot_busy_out),
		.owner_tag     (owner_tag)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int node_cap(input int n);
		int c;
		c = (cap_word >> (4 * n)) & 15;
		if (c > SPN)
			c = SPN;
		return c;
	endfunction

	function automatic bit table_step(input func_t f, input logic [TAG_W-1:0] tag,
			input int node, input int slot, input bit last, output alloc_result_t r);
		int c;
		int idx;
		int n;
		r = '0;
		c = node_cap(node);
		idx = (c != 0 && slot < c) ? node * SPN + slot : 0;
		n = 0;
		case (f)
			FN_PAIR: begin
				if (c == 0 || slot >= c || slot_taken[idx])
					req_bad = 1;
				else
					slot_pend[idx] = 1;
				if (!last)
					return 0;
				if (!req_bad) begin
					for (int i = 0; i < TOTAL; i++) begin
						if (slot_pend[i] && !slot_taken[i]) begin
							slot_taken[i] = 1;
							slot_tag[i] = tag;
							n++;
						end
					end
					occupied += n;
					if (occupied > TOTAL)
						occupied = TOTAL;
					r.st = ST_GRANT;
				end else begin
					r.st = ST_REJECT;
				end
				for (int i = 0; i < TOTAL; i++)
					slot_pend[i] = 0;
				req_bad = 0;
			end
			FN_RELEASE: begin
				for (int i = 0; i < TOTAL; i++) begin
					if (slot_taken[i] && slot_tag[i] == tag) begin
						slot_taken[i] = 0;
						slot_tag[i] = '0;
						n++;
					end
				end
				occupied = (occupied > n) ? occupied - n : 0;
				r.st = ST_RELEASED;
			end
			FN_QUERY: begin
				if (c == 0) begin
					r.st = ST_BAD;
				end else begin
					for (int i = 0; i < c; i++)
						if (!slot_taken[node * SPN + i])
							n++;
					r.st = ST_ANSWER;
				end
			end
			default: begin
				if (c == 0 || slot >= c) begin
					r.st = ST_BAD;
				end else begin
					r.st = ST_ANSWER;
					r.busy = slot_taken[idx];
					r.owner = slot_taken[idx] ? slot_tag[idx] : '0;
				end
			end
		endcase
		r.cnt = CNT_W'(n);
		r.used = CNT_W'(occupied);
		return 1;
	endfunction

	function automatic int idle_len(input int pct);
		int g;
		g = 0;
		while (g < 20 && $urandom_range(99) < pct)
			g++;
		return g;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(99) < 85)
			return tag_pool[$urandom_range(7)];
		return TAG_W'($urandom);
	endfunction

	task automatic pick_spot(output int nd, output int sl);
		int tries;
		tries = 0;
		nd = $urandom_range(7);
		while (node_cap(nd) == 0 && tries < 3) begin
			nd = $urandom_range(7);
			tries++;
		end
		if (node_cap(nd) != 0 && $urandom_range(9) != 0)
			sl = $urandom_range(node_cap(nd) - 1);
		else
			sl = $urandom_range(15);
	endtask

	function automatic void row(input logic typed, input func_t f, input int tag,
			input int node, input int slot, input logic last, input status_t st,
			input int cnt, input int used);
		plan_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.f = f;
		r.tag = TAG_W'(tag);
		r.node = NODE_W'(node);
		r.slot = SLOT_W'(slot);
		r.last = last;
		r.typed = typed;
		r.res.st = st;
		r.res.cnt = CNT_W'(cnt);
		r.res.used = CNT_W'(used);
		plan = {plan, r};
	endfunction

	function automatic void cfg_row(input logic [CFG_W-1:0] d);
		plan_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.cdata = d;
		plan = {plan, r};
	endfunction

	task automatic send_item(input func_t f, input logic [TAG_W-1:0] tag,
			input logic [NODE_W-1:0] node, input logic [SLOT_W-1:0] slot,
			input logic last, input logic typed, input alloc_result_t want);
		alloc_result_t r;
		int gap;
		in_valid <= 1'b1;
		offer_up = 1;
		func <= f;
		job_tag <= tag;
		node_sel <= node;
		slot_sel <= slot;
		last_pair <= last;
		do @(posedge clk); while (!in_ready);
		if (table_step(f, tag, int'(node), int'(slot), last, r))
			results_due = {results_due, (typed ? want : r)};
		items_sent++;
		gap = idle_len(send_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			offer_up = 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_cfg(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_word = v;
	endtask

	// wait for the table to go idle
	task automatic settle();
		if (offer_up) begin
			in_valid <= 1'b0;
			offer_up = 0;
		end
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_op();
		int pick;
		int n;
		int nd;
		int sl;
		logic [TAG_W-1:0] tg;
		pick = $urandom_range(99);
		if (pick < 50) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
			tg = pick_tag();
			for (int k = 0; k < n; k++) begin
				pick_spot(nd, sl);
				send_item(FN_PAIR, (k == n - 1 || $urandom_range(3) != 0) ? tg : TAG_W'($urandom),
					NODE_W'(nd), SLOT_W'(sl), k == n - 1, 1'b0, '0);
			end
		end else if (pick < 65) begin
			send_item(FN_RELEASE, pick_tag(), NODE_W'($urandom), SLOT_W'($urandom),
				1'($urandom), 1'b0, '0);
		end else if (pick < 80) begin
			send_item(FN_QUERY, TAG_W'($urandom), NODE_W'($urandom), SLOT_W'($urandom),
				1'($urandom), 1'b0, '0);
		end else if (pick < 95) begin
			pick_spot(nd, sl);
			send_item(FN_READ, TAG_W'($urandom), NODE_W'(nd), SLOT_W'(sl), 1'($urandom),
				1'b0, '0);
		end else begin
			// stray pair, may leave a request open
			send_item(FN_PAIR, TAG_W'($urandom), NODE_W'($urandom), SLOT_W'($urandom),
				1'($urandom), 1'b0, '0);
		end
	endtask

	function automatic void check_field(input string what, input logic [TAG_W-1:0] want,
			input logic [TAG_W-1:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		alloc_result_t e;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t mismatch transaction expected none actual status %0h",
					$time, status);
				mismatches++;
			end else begin
				e = results_due.pop_front();
				check_field("status", TAG_W'(e.st), TAG_W'(status));
				check_field("count", TAG_W'(e.cnt), TAG_W'(count));
				check_field("used_total", TAG_W'(e.used), TAG_W'(used_total));
				check_field("slot_busy_out", TAG_W'(e.busy), TAG_W'(slot_busy_out));
				check_field("owner_tag", e.owner, owner_tag);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("gpu_slot_allocation_table_top verification failed");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				n = hold_len;
				hold_len = 0;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : main
		logic [CFG_W-1:0] cw;
		int target;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FN_PAIR;
		job_tag = '0;
		node_sel = '0;
		slot_sel = '0;
		last_pair = 1'b0;
		cap_word = '0;
		req_bad = 0;
		occupied = 0;
		for (int i = 0; i < TOTAL; i++) begin
			slot_taken[i] = 0;
			slot_tag[i] = '0;
			slot_pend[i] = 0;
		end
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = TAG_W'($urandom);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing configured after reset
		row(1, FN_QUERY, 0, 0, 0, 0, ST_BAD, 0, 0);
		row(1, FN_READ, 0, 7, 15, 0, ST_BAD, 0, 0);
		// capacities 8 1 15 0 3 8 2 15 from node 0 up
		cfg_row(32'hF2830F18);
		row(1, FN_QUERY, 0, 0, 0, 0, ST_ANSWER, 8, 0);
		row(1, FN_QUERY, 0, 3, 0, 0, ST_BAD, 0, 0);
		row(1, FN_READ, 0, 1, 1, 0, ST_BAD, 0, 0);
		row(1, FN_READ, 0, 0, 0, 0, ST_ANSWER, 0, 0);
		// repeated pair, tag from last pair
		row(0, FN_PAIR, 'h1111, 0, 0, 0, ST_GRANT, 0, 0);
		row(0, FN_PAIR, 'h2222, 0, 0, 0, ST_GRANT, 0, 0);
		row(0, FN_PAIR, 'hFFFF, 2, 7, 1, ST_GRANT, 0, 0);
		row(0, FN_READ, 0, 2, 7, 0, ST_GRANT, 0, 0);
		row(0, FN_PAIR, 0, 1, 0, 1, ST_GRANT, 0, 0);
		// busy slot, absent node, slot past capacity, clamped capacity
		row(1, FN_PAIR, 5, 0, 0, 1, ST_REJECT, 0, 3);
		row(0, FN_PAIR, 5, 3, 0, 0, ST_GRANT, 0, 0);
		row(1, FN_PAIR, 5, 0, 1, 1, ST_REJECT, 0, 3);
		row(1, FN_PAIR, 5, 4, 3, 1, ST_REJECT, 0, 3);
		row(1, FN_PAIR, 5, 7, 15, 1, ST_REJECT, 0, 3);
		row(0, FN_PAIR, 'h1111, 7, 7, 1, ST_GRANT, 0, 0);
		row(0, FN_QUERY, 0, 2, 0, 0, ST_GRANT, 0, 0);
		row(0, FN_RELEASE, 'h1111, 0, 0, 0, ST_GRANT, 0, 0);
		row(0, FN_RELEASE, 'hFFFF, 5, 9, 1, ST_GRANT, 0, 0);
		row(0, FN_RELEASE, 'hABCD, 7, 15, 0, ST_GRANT, 0, 0);
		// release past a shrunk capacity
		cfg_row(32'h00000008);
		row(1, FN_QUERY, 0, 1, 0, 0, ST_BAD, 0, 1);
		row(0, FN_RELEASE, 0, 1, 0, 0, ST_GRANT, 0, 0);
		// capacity changed inside an open request
		cfg_row(32'hFFFFFFFF);
		row(0, FN_PAIR, 'h7777, 0, 7, 0, ST_GRANT, 0, 0);
		cfg_row(32'h00000001);
		row(0, FN_PAIR, 'h8000, 0, 0, 1, ST_GRANT, 0, 0);
		row(1, FN_READ, 0, 0, 7, 0, ST_BAD, 0, 2);
		row(0, FN_QUERY, 0, 0, 0, 0, ST_GRANT, 0, 0);
		row(0, FN_RELEASE, 'h8000, 0, 0, 0, ST_GRANT, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_cfg(plan[i].cdata);
			end else begin
				send_item(plan[i].f, plan[i].tag, plan[i].node, plan[i].slot, plan[i].last,
					plan[i].typed, plan[i].res);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: cw = 32'hFFFFFFFF;
				1: cw = 32'h88888888;
				2: cw = 32'h11111111;
				5: cw = 32'h00000000;
				6: cw = 32'h12345678;
				default: cw = $urandom;
			endcase
			write_cfg(cw);
			send_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 7 : 0;
			stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 7 : 0;
			// long output hold so the block backs up
			if (ph == 4)
				hold_len = 600;
			target = items_sent + ((cw == 0) ? 40 : 185);
			while (items_sent < target)
				random_op();
		end

		settle();
		if (mismatches == 0)
			$display("gpu_slot_allocation_table_top verification clean");
		else
			$display("gpu_slot_allocation_table_top verification failed");
		$finish;
	end

endmodule
